### sv/turnout_servo_event_controller_defines.svh
// Assertion macros for the turnout servo event controller.
`ifndef TURNOUT_SERVO_EVENT_CONTROLLER_DEFINES_SVH
`define TURNOUT_SERVO_EVENT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TSEC_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tsec assertion failed");
// next-cycle implication
`define TSEC_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tsec assertion failed");
`else
`define TSEC_ASSERT_IMP(label, clk, rst_n, a, b)
`define TSEC_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

### sv/tsec_pkg.sv
// Types, constants and helper functions shared by the turnout servo controller.
`timescale 1ns / 1ps
package tsec_pkg;

  localparam int MAX_RES = 8;
  localparam int N_CAND  = 12;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 3;

  localparam logic [10:0] WAIT_SHORT = 11'd1000;
  localparam logic [10:0] WAIT_LONG  = 11'd2000;

  typedef enum logic [1:0] {
    KIND_EVENT   = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_REACHED = 2'd2,
    KIND_REPORT  = 2'd3
  } tsec_kind_t;

  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_EASE = 2'd1,
    MOVE_SNAP = 2'd2
  } tsec_move_t;

  typedef enum logic [1:0] {
    PH_MOVE_THROWN = 2'd0,
    PH_WAIT_THROWN = 2'd1,
    PH_MOVE_CLOSED = 2'd2,
    PH_WAIT_CLOSED = 2'd3
  } tsec_phase_t;

  typedef enum logic [2:0] {
    CFG_ANGLES     = 3'd0,
    CFG_MOVE_EV    = 3'd1,
    CFG_COND_EV    = 3'd2,
    CFG_LEAVE_EV   = 3'd3,
    CFG_REACH_EV   = 3'd4,
    CFG_SERVO_EV   = 3'd5,
    CFG_TEST_EV    = 3'd6,
    CFG_UNUSED     = 3'd7
  } tsec_cfg_idx_t;

  // position numbers
  localparam int THROWN_POS = 0;
  localparam int MID_POS    = 1;
  localparam int CLOSED_POS = 2;
  // servo_events slots
  localparam int SEV_TOGGLE = 0;
  localparam int SEV_LOCKED = 1;
  localparam int SEV_UNLOCK = 2;
  // test_events slots
  localparam int TEV_START = 0;
  localparam int TEV_STOP  = 1;

  typedef struct packed {
    logic [23:0] angles;
    logic [47:0] move_ev;
    logic [47:0] cond_ev;
    logic [47:0] leave_ev;
    logic [47:0] reach_ev;
    logic [47:0] servo_ev;
    logic [31:0] test_ev;
  } tsec_cfg_t;

  typedef struct packed {
    tsec_kind_t  kind;
    logic [15:0] ev;
    logic [7:0]  angle;
    logic        inc;
  } tsec_item_t;

  typedef struct packed {
    logic        ev_valid;
    logic [15:0] ev;
    tsec_move_t  mk;
    logic [7:0]  ang;
  } tsec_res_t;

  typedef struct packed {
    logic        test_active;
    tsec_phase_t test_phase;
    logic [10:0] wait_ms;
    logic        locked;
  } tsec_state_t;

  function automatic logic [7:0] ang_of(input logic [23:0] angles, input int p);
    return angles[8*p +: 8];
  endfunction

  function automatic logic [15:0] ev_of(input logic [47:0] evs, input int k);
    return evs[16*k +: 16];
  endfunction

  // leaving event of the first position at this angle, 0 if none
  function automatic logic [15:0] leaving_for(input tsec_cfg_t cfg, input logic [7:0] cur);
    logic [15:0] r;
    r = 16'd0;
    for (int p = CLOSED_POS; p >= THROWN_POS; p--) begin
      if (ang_of(cfg.angles, p) == cur) r = ev_of(cfg.leave_ev, p);
    end
    return r;
  endfunction

  function automatic tsec_res_t mk_res(input logic [15:0] ev, input tsec_move_t mk,
                                       input logic [7:0] a);
    tsec_res_t r;
    r.ev_valid = 1'b1;
    r.ev       = ev;
    r.mk       = mk;
    r.ang      = (mk == MOVE_NONE) ? 8'd0 : a;
    return r;
  endfunction

  function automatic tsec_res_t go_to(input tsec_cfg_t cfg, input int p,
                                      input logic [7:0] cur);
    tsec_res_t r;
    if (cur == ang_of(cfg.angles, p)) r = mk_res(ev_of(cfg.reach_ev, p), MOVE_NONE, 8'd0);
    else r = mk_res(leaving_for(cfg, cur), MOVE_EASE, ang_of(cfg.angles, p));
    return r;
  endfunction

endpackage

### sv/tsec_cfg_regs.sv
// Configuration register file of the turnout servo controller.
`timescale 1ns / 1ps
module tsec_cfg_regs
  import tsec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output tsec_cfg_t   cfg
);

  tsec_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (tsec_cfg_idx_t'(cfg_index))
        CFG_ANGLES:   cfg_nxt.angles   = cfg_data[23:0];
        CFG_MOVE_EV:  cfg_nxt.move_ev  = cfg_data;
        CFG_COND_EV:  cfg_nxt.cond_ev  = cfg_data;
        CFG_LEAVE_EV: cfg_nxt.leave_ev = cfg_data;
        CFG_REACH_EV: cfg_nxt.reach_ev = cfg_data;
        CFG_SERVO_EV: cfg_nxt.servo_ev = cfg_data;
        CFG_TEST_EV:  cfg_nxt.test_ev  = cfg_data[31:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/tsec_decode.sv
// Combinational decode of one item into its result list and next control state.
`timescale 1ns / 1ps
module tsec_decode
  import tsec_pkg::*;
(
  input  tsec_item_t               item,
  input  tsec_cfg_t                cfg,
  input  tsec_state_t              state,
  output tsec_res_t [MAX_RES-1:0]  list,
  output logic [CNT_W-1:0]         count,
  output logic                     known,
  output tsec_state_t              state_nxt
);

  tsec_res_t [N_CAND-1:0] cand;
  logic [N_CAND-1:0]      en;

  // candidate results in emission order, plus state update
  always_comb begin
    logic [7:0]  cur2;
    logic        st, sp, act_post, cont, tog, mv, lk;
    logic [10:0] dec;
    logic        wait_nz;
    cand      = '0;
    en        = '0;
    known     = 1'b0;
    state_nxt = state;
    cur2      = item.angle;
    st = 1'b0; sp = 1'b0; act_post = 1'b0; cont = 1'b0; tog = 1'b0; mv = 1'b0;
    lk = state.locked;
    dec = state.wait_ms - 11'd1;
    wait_nz = (state.wait_ms != 11'd0);

    case (item.kind)
      KIND_EVENT: begin
        for (int k = 0; k < 2; k++) begin
          if (ev_of({16'd0, cfg.test_ev}, k) == item.ev) known = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
          if (ev_of(cfg.servo_ev, k) == item.ev || ev_of(cfg.move_ev, k) == item.ev ||
              ev_of(cfg.cond_ev, k) == item.ev || ev_of(cfg.leave_ev, k) == item.ev ||
              ev_of(cfg.reach_ev, k) == item.ev) known = 1'b1;
        end
        st = (cfg.test_ev[15:0] == item.ev);
        sp = (cfg.test_ev[31:16] == item.ev);
        act_post = sp ? 1'b0 : (st ? 1'b1 : state.test_active);
        if (st) begin
          state_nxt.test_phase = PH_MOVE_THROWN;
          state_nxt.wait_ms    = 11'd0;
        end
        state_nxt.test_active = act_post;
        // test stop: snap to mid, current angle taken as mid afterwards
        if (sp) begin
          en[0]   = 1'b1;
          cand[0] = mk_res(ev_of(cfg.leave_ev, THROWN_POS), MOVE_SNAP,
                           ang_of(cfg.angles, MID_POS));
          en[1]   = 1'b1;
          cand[1] = mk_res(ev_of(cfg.leave_ev, CLOSED_POS), MOVE_NONE, 8'd0);
          en[2]   = 1'b1;
          cand[2] = mk_res(ev_of(cfg.reach_ev, MID_POS), MOVE_NONE, 8'd0);
          cur2    = ang_of(cfg.angles, MID_POS);
        end
        cont = !act_post;
        tog  = (ev_of(cfg.servo_ev, SEV_TOGGLE) == item.ev);
        if (cont && tog) begin
          en[3]   = (cur2 == ang_of(cfg.angles, THROWN_POS));
          cand[3] = mk_res(ev_of(cfg.leave_ev, THROWN_POS), MOVE_EASE,
                           ang_of(cfg.angles, CLOSED_POS));
          en[4]   = (cur2 == ang_of(cfg.angles, MID_POS));
          cand[4] = mk_res(ev_of(cfg.leave_ev, MID_POS), MOVE_EASE,
                           ang_of(cfg.angles, CLOSED_POS));
          en[5]   = (cur2 == ang_of(cfg.angles, CLOSED_POS));
          cand[5] = mk_res(ev_of(cfg.leave_ev, CLOSED_POS), MOVE_EASE,
                           ang_of(cfg.angles, THROWN_POS));
        end
        mv = cont && !tog;
        for (int p = 0; p < 3; p++) begin
          en[6+p]   = mv && (ev_of(cfg.move_ev, p) == item.ev);
          cand[6+p] = go_to(cfg, p, cur2);
        end
        // first conditional match while unlocked moves and locks; later ones report
        for (int p = 0; p < 3; p++) begin
          if (mv && (ev_of(cfg.cond_ev, p) == item.ev)) begin
            en[9+p] = 1'b1;
            if (lk) cand[9+p] = mk_res(ev_of(cfg.servo_ev, SEV_LOCKED), MOVE_NONE, 8'd0);
            else    cand[9+p] = go_to(cfg, p, cur2);
            lk = 1'b1;
          end
        end
        state_nxt.locked = lk;
      end
      KIND_TICK: begin
        if (state.test_active) begin
          if (wait_nz) state_nxt.wait_ms = dec;
          if (!wait_nz || dec == 11'd0) begin
            case (state.test_phase)
              PH_MOVE_THROWN: begin
                en[0]   = 1'b1;
                cand[0] = mk_res(leaving_for(cfg, item.angle), MOVE_EASE,
                                 ang_of(cfg.angles, THROWN_POS));
                state_nxt.wait_ms    = WAIT_SHORT;
                state_nxt.test_phase = PH_WAIT_THROWN;
              end
              PH_WAIT_THROWN: begin
                if (item.angle == ang_of(cfg.angles, THROWN_POS)) begin
                  state_nxt.wait_ms    = WAIT_LONG;
                  state_nxt.test_phase = PH_MOVE_CLOSED;
                end
              end
              PH_MOVE_CLOSED: begin
                en[0]   = 1'b1;
                cand[0] = mk_res(leaving_for(cfg, item.angle), MOVE_EASE,
                                 ang_of(cfg.angles, CLOSED_POS));
                state_nxt.wait_ms    = WAIT_SHORT;
                state_nxt.test_phase = PH_WAIT_CLOSED;
              end
              PH_WAIT_CLOSED: begin
                if (item.angle == ang_of(cfg.angles, CLOSED_POS)) begin
                  state_nxt.wait_ms    = WAIT_LONG;
                  state_nxt.test_phase = PH_MOVE_THROWN;
                end
              end
              default: state_nxt.test_phase = state.test_phase;
            endcase
          end
        end
      end
      KIND_REACHED: begin
        if (item.angle == ang_of(cfg.angles, THROWN_POS)) begin
          en[0]   = 1'b1;
          cand[0] = mk_res(ev_of(cfg.reach_ev, THROWN_POS), MOVE_NONE, 8'd0);
        end else if (item.angle == ang_of(cfg.angles, MID_POS)) begin
          en[0]   = 1'b1;
          cand[0] = mk_res(item.inc ? ev_of(cfg.reach_ev, MID_POS)
                                    : ev_of(cfg.leave_ev, MID_POS), MOVE_NONE, 8'd0);
        end else if (item.angle == ang_of(cfg.angles, CLOSED_POS)) begin
          en[0]   = 1'b1;
          cand[0] = mk_res(ev_of(cfg.reach_ev, CLOSED_POS), MOVE_NONE, 8'd0);
        end
      end
      KIND_REPORT: begin
        en[0]   = (item.angle == ang_of(cfg.angles, THROWN_POS));
        cand[0] = mk_res(ev_of(cfg.reach_ev, THROWN_POS), MOVE_NONE, 8'd0);
        en[1]   = en[0];
        cand[1] = mk_res(ev_of(cfg.leave_ev, CLOSED_POS), MOVE_NONE, 8'd0);
        en[2]   = (item.angle == ang_of(cfg.angles, CLOSED_POS));
        cand[2] = mk_res(ev_of(cfg.reach_ev, CLOSED_POS), MOVE_NONE, 8'd0);
        en[3]   = en[2];
        cand[3] = mk_res(ev_of(cfg.leave_ev, THROWN_POS), MOVE_NONE, 8'd0);
        en[4]   = (item.angle == ang_of(cfg.angles, MID_POS));
        cand[4] = mk_res(ev_of(cfg.leave_ev, THROWN_POS), MOVE_NONE, 8'd0);
        en[5]   = en[4];
        cand[5] = mk_res(ev_of(cfg.leave_ev, CLOSED_POS), MOVE_NONE, 8'd0);
      end
      default: state_nxt = state;
    endcase
  end

  // pack enabled candidates into the list; entries past the eighth are dropped
  always_comb begin
    logic [CNT_W-1:0] pos;
    pos  = '0;
    list = '0;
    for (int i = 0; i < N_CAND; i++) begin
      if (en[i]) begin
        if (pos < CNT_W'(MAX_RES)) list[pos[IDX_W-1:0]] = cand[i];
        pos = pos + CNT_W'(1);
      end
    end
    if (pos > CNT_W'(MAX_RES)) count = CNT_W'(MAX_RES);
    else count = pos;
    // a received event always answers; slot 0 is already the empty result
    if (item.kind == KIND_EVENT && pos == '0) count = CNT_W'(1);
  end

endmodule

### sv/tsec_result_buf.sv
// Result list register that hands out one result item per cycle unless stalled.
`timescale 1ns / 1ps
module tsec_result_buf
  import tsec_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load_req,
  input  tsec_res_t [MAX_RES-1:0] list,
  input  logic [CNT_W-1:0]        count,
  input  logic                    known,
  output logic                    ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output tsec_res_t               res,
  output logic                    res_known,
  output logic                    res_last
);

  tsec_res_t [MAX_RES-1:0] list_r;
  logic                    known_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    pop, load;

  assign out_valid = (cnt_r != '0);
  assign res_last  = (cnt_r == CNT_W'(1));
  assign pop       = out_valid && !out_stall;
  assign ready     = !out_valid || (pop && res_last);
  assign load      = load_req && ready;
  assign res       = list_r[idx_r];
  assign res_known = known_r;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = count;
      idx_nxt = '0;
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list_r  <= list;
      known_r <= known;
    end
  end

endmodule

### sv/turnout_servo_event_controller.sv
// Top level of the turnout servo event controller.
//
// Input channel (in_*): one item per handshake, accepted when in_valid is high
//   and in_stall low. Kinds: received event, millisecond tick, angle reached,
//   state report; each carries the current servo angle.
// Result channel (out_*): zero to eight result items per input item, in order,
//   out_last marking the final one. A received event always gives at least one.
// Configuration (cfg_*): register writes by index, taken in any cycle
//   (cfg_ready is always high); write only while the block is idle.
// Path: an item waits in the input register, is decoded in one pass and its
//   whole result list loads into the result register once that is ready; the
//   first result then shows on out_* and is taken when out_stall is low.
// Throughput: one result item per cycle leaves while out_stall is low, and
//   items with at most one result flow at one per cycle; a longer list holds the
//   result register until drained; the next item waits in the input register.
// Reset (rst_n low, synchronous): config and state zero, test idle at phase move
//   to thrown, servo unlocked, no result pending. Only reset clears the lock.
// A stalled result holds; in_stall rises once the input register is also full.
`timescale 1ns / 1ps
`include "turnout_servo_event_controller_defines.svh"
module turnout_servo_event_controller
  import tsec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_event_number,
  input  logic [7:0]  in_current_angle,
  input  logic        in_increasing,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_valid,
  output logic [15:0] out_event_out,
  output logic [1:0]  out_move_kind,
  output logic [7:0]  out_move_angle,
  output logic        out_index_known,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  tsec_cfg_t               cfg;
  tsec_item_t              item_r;
  logic                    hold_r, hold_nxt;
  tsec_state_t             state_r, state_nxt;
  tsec_res_t [MAX_RES-1:0] list;
  logic [CNT_W-1:0]        count;
  logic                    known;
  logic                    buf_ready;
  logic                    advance;
  tsec_res_t               res;

  tsec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = hold_r && buf_ready;
  assign in_stall = hold_r && !buf_ready;

  always_comb begin
    hold_nxt = hold_r;
    if (!hold_r || buf_ready) hold_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      state_r <= '{test_active: 1'b0, test_phase: PH_MOVE_THROWN,
                   wait_ms: 11'd0, locked: 1'b0};
    end else begin
      hold_r <= hold_nxt;
      if (advance) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.kind  <= tsec_kind_t'(in_kind);
      item_r.ev    <= in_event_number;
      item_r.angle <= in_current_angle;
      item_r.inc   <= in_increasing;
    end
  end

  tsec_decode u_decode (
    .item      (item_r),
    .cfg       (cfg),
    .state     (state_r),
    .list      (list),
    .count     (count),
    .known     (known),
    .state_nxt (state_nxt)
  );

  tsec_result_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_req  (hold_r),
    .list      (list),
    .count     (count),
    .known     (known),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .res_known (out_index_known),
    .res_last  (out_last)
  );

  assign out_event_valid = res.ev_valid;
  assign out_event_out   = res.ev;
  assign out_move_kind   = res.mk;
  assign out_move_angle  = res.ang;

  // the lock is never released once set
  `TSEC_ASSERT_NXT(a_lock_sticky, clk, rst_n, state_r.locked, state_r.locked)
  // the input side stalls only behind pending results
  `TSEC_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid)
  // wait counter never exceeds the long wait
  `TSEC_ASSERT_IMP(a_wait_range, clk, rst_n, 1'b1, state_r.wait_ms <= WAIT_LONG)
  // last result taken with nothing queued leaves the output empty
  `TSEC_ASSERT_NXT(a_drain, clk, rst_n, out_valid && out_last && !out_stall && !hold_r, !out_valid)

endmodule

### tb/turnout_cmd_checker.sv
// Checker for the turnout servo controller: predicts result items and compares them.
`timescale 1ns / 1ps
module turnout_cmd_checker
  import tsec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_event_number,
  input  logic [7:0]  in_current_angle,
  input  logic        in_increasing,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_event_valid,
  input  logic [15:0] out_event_out,
  input  logic [1:0]  out_move_kind,
  input  logic [7:0]  out_move_angle,
  input  logic        out_index_known,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          errors,
  output int          outstanding,
  output int          items_seen,
  output int          results_seen,
  output int          swings
);

  typedef struct packed {
    logic        ev_valid;
    logic [15:0] ev;
    tsec_move_t  mk;
    logic [7:0]  ang;
    logic        known;
    logic        last;
  } servo_cmd_t;

  tsec_cfg_t   regs;
  logic        testing;
  tsec_phase_t phase;
  logic [10:0] wait_ms;
  logic        locked;

  servo_cmd_t  batch[$];
  servo_cmd_t  expected_cmds[$];
  servo_cmd_t  want;
  servo_cmd_t  got;

  function automatic logic [7:0] pos_angle(input int p);
    return regs.angles[8*p +: 8];
  endfunction

  function automatic logic [15:0] slot(input logic [47:0] r, input int k);
    return r[16*k +: 16];
  endfunction

  // first position sitting at this angle wins; no match sends event 0
  function automatic logic [15:0] leaving_event(input logic [7:0] cur);
    logic [15:0] r;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    for (int p = 0; p < 3; p++) begin
      if (!hit && pos_angle(p) == cur) begin
        r   = slot(regs.leave_ev, p);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic known_number(input logic [15:0] e);
    logic k;
    k = (slot(regs.test_ev, TEV_START) == e) || (slot(regs.test_ev, TEV_STOP) == e);
    for (int p = 0; p < 3; p++) begin
      if (slot(regs.servo_ev, p) == e || slot(regs.move_ev, p) == e ||
          slot(regs.cond_ev, p) == e || slot(regs.leave_ev, p) == e ||
          slot(regs.reach_ev, p) == e)
        k = 1'b1;
    end
    return k;
  endfunction

  task automatic add_cmd(input logic v, input logic [15:0] ev, input tsec_move_t mk,
                         input logic [7:0] a);
    servo_cmd_t c;
    if (batch.size() < MAX_RES) begin
      c.ev_valid = v;
      c.ev       = ev;
      c.mk       = mk;
      c.ang      = (mk == MOVE_NONE) ? 8'd0 : a;
      c.known    = 1'b0;
      c.last     = 1'b0;
      batch.insert(batch.size(), c);
    end
  endtask

  task automatic head_to(input int p, input logic [7:0] cur);
    if (cur == pos_angle(p)) add_cmd(1'b1, slot(regs.reach_ev, p), MOVE_NONE, 8'd0);
    else add_cmd(1'b1, leaving_event(cur), MOVE_EASE, pos_angle(p));
  endtask

  task automatic react_event(input logic [15:0] e, input logic [7:0] cur);
    if (e == slot(regs.test_ev, TEV_START)) begin
      phase   = PH_MOVE_THROWN;
      wait_ms = '0;
      testing = 1'b1;
    end
    if (e == slot(regs.test_ev, TEV_STOP)) begin
      add_cmd(1'b1, slot(regs.leave_ev, THROWN_POS), MOVE_SNAP, pos_angle(MID_POS));
      add_cmd(1'b1, slot(regs.leave_ev, CLOSED_POS), MOVE_NONE, 8'd0);
      add_cmd(1'b1, slot(regs.reach_ev, MID_POS), MOVE_NONE, 8'd0);
      testing = 1'b0;
      cur     = pos_angle(MID_POS);   // servo counts as parked at mid from here on
    end
    if (testing) return;
    if (e == slot(regs.servo_ev, SEV_TOGGLE)) begin
      if (cur == pos_angle(THROWN_POS))
        add_cmd(1'b1, slot(regs.leave_ev, THROWN_POS), MOVE_EASE, pos_angle(CLOSED_POS));
      if (cur == pos_angle(MID_POS))
        add_cmd(1'b1, slot(regs.leave_ev, MID_POS), MOVE_EASE, pos_angle(CLOSED_POS));
      if (cur == pos_angle(CLOSED_POS))
        add_cmd(1'b1, slot(regs.leave_ev, CLOSED_POS), MOVE_EASE, pos_angle(THROWN_POS));
      return;
    end
    for (int p = 0; p < 3; p++)
      if (e == slot(regs.move_ev, p)) head_to(p, cur);
    for (int p = 0; p < 3; p++) begin
      if (e == slot(regs.cond_ev, p)) begin
        if (locked) add_cmd(1'b1, slot(regs.servo_ev, SEV_LOCKED), MOVE_NONE, 8'd0);
        else begin
          locked = 1'b1;
          head_to(p, cur);
        end
      end
    end
  endtask

  task automatic react_tick(input logic [7:0] cur);
    if (!testing) return;
    if (wait_ms != 0) wait_ms = wait_ms - 11'd1;
    if (wait_ms != 0) return;
    case (phase)
      PH_MOVE_THROWN: begin
        add_cmd(1'b1, leaving_event(cur), MOVE_EASE, pos_angle(THROWN_POS));
        wait_ms = WAIT_SHORT;
        phase   = PH_WAIT_THROWN;
      end
      PH_WAIT_THROWN: begin
        if (cur == pos_angle(THROWN_POS)) begin
          wait_ms = WAIT_LONG;
          phase   = PH_MOVE_CLOSED;
        end
      end
      PH_MOVE_CLOSED: begin
        add_cmd(1'b1, leaving_event(cur), MOVE_EASE, pos_angle(CLOSED_POS));
        wait_ms = WAIT_SHORT;
        phase   = PH_WAIT_CLOSED;
      end
      default: begin
        if (cur == pos_angle(CLOSED_POS)) begin
          wait_ms = WAIT_LONG;
          phase   = PH_MOVE_THROWN;
          swings++;
        end
      end
    endcase
  endtask

  task automatic react_reached(input logic [7:0] cur, input logic inc);
    if (cur == pos_angle(THROWN_POS))
      add_cmd(1'b1, slot(regs.reach_ev, THROWN_POS), MOVE_NONE, 8'd0);
    else if (cur == pos_angle(MID_POS))
      add_cmd(1'b1, inc ? slot(regs.reach_ev, MID_POS) : slot(regs.leave_ev, MID_POS),
              MOVE_NONE, 8'd0);
    else if (cur == pos_angle(CLOSED_POS))
      add_cmd(1'b1, slot(regs.reach_ev, CLOSED_POS), MOVE_NONE, 8'd0);
  endtask

  task automatic react_report(input logic [7:0] cur);
    if (cur == pos_angle(THROWN_POS)) begin
      add_cmd(1'b1, slot(regs.reach_ev, THROWN_POS), MOVE_NONE, 8'd0);
      add_cmd(1'b1, slot(regs.leave_ev, CLOSED_POS), MOVE_NONE, 8'd0);
    end
    if (cur == pos_angle(CLOSED_POS)) begin
      add_cmd(1'b1, slot(regs.reach_ev, CLOSED_POS), MOVE_NONE, 8'd0);
      add_cmd(1'b1, slot(regs.leave_ev, THROWN_POS), MOVE_NONE, 8'd0);
    end
    if (cur == pos_angle(MID_POS)) begin
      add_cmd(1'b1, slot(regs.leave_ev, THROWN_POS), MOVE_NONE, 8'd0);
      add_cmd(1'b1, slot(regs.leave_ev, CLOSED_POS), MOVE_NONE, 8'd0);
    end
  endtask

  task automatic predict_commands(input tsec_kind_t kind, input logic [15:0] e,
                                  input logic [7:0] cur, input logic inc);
    logic known;
    batch.delete();
    known = 1'b0;
    case (kind)
      KIND_EVENT: begin
        known = known_number(e);
        react_event(e, cur);
        if (batch.size() == 0) add_cmd(1'b0, 16'd0, MOVE_NONE, 8'd0);
      end
      KIND_TICK:    react_tick(cur);
      KIND_REACHED: react_reached(cur, inc);
      default:      react_report(cur);
    endcase
    foreach (batch[i]) begin
      batch[i].known = known;
      batch[i].last  = (i == batch.size() - 1);
      expected_cmds.insert(expected_cmds.size(), batch[i]);
    end
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: result %0d, %s mismatch: expected %0h, actual %0h",
               $time, results_seen, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs    = '0;
      testing = 1'b0;
      phase   = PH_MOVE_THROWN;
      wait_ms = '0;
      locked  = 1'b0;
      expected_cmds.delete();
      errors       = 0;
      items_seen   = 0;
      results_seen = 0;
      swings       = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (tsec_cfg_idx_t'(cfg_index))
          CFG_ANGLES:   regs.angles   = cfg_data[23:0];
          CFG_MOVE_EV:  regs.move_ev  = cfg_data;
          CFG_COND_EV:  regs.cond_ev  = cfg_data;
          CFG_LEAVE_EV: regs.leave_ev = cfg_data;
          CFG_REACH_EV: regs.reach_ev = cfg_data;
          CFG_SERVO_EV: regs.servo_ev = cfg_data;
          CFG_TEST_EV:  regs.test_ev  = cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.ev_valid = out_event_valid;
        got.ev       = out_event_out;
        got.mk       = tsec_move_t'(out_move_kind);
        got.ang      = out_move_angle;
        got.known    = out_index_known;
        got.last     = out_last;
        if (expected_cmds.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item: expected none, actual %p", $time, got);
        end else begin
          want = expected_cmds.pop_front();
          check_field("event_valid", want.ev_valid, got.ev_valid);
          check_field("event_out", want.ev, got.ev);
          check_field("move_kind", want.mk, got.mk);
          check_field("move_angle", want.ang, got.ang);
          check_field("index_known", want.known, got.known);
          check_field("last", want.last, got.last);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        predict_commands(tsec_kind_t'(in_kind), in_event_number, in_current_angle,
                         in_increasing);
        items_seen++;
      end
    end
    outstanding <= expected_cmds.size();
  end

endmodule

### tb/tb_top.sv
// Testbench top for the turnout servo controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import tsec_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  // directed configuration
  localparam logic [7:0]  ANG_T     = 8'd20;
  localparam logic [7:0]  ANG_M     = 8'd90;
  localparam logic [7:0]  ANG_C     = 8'd160;
  localparam logic [15:0] EV_MOVE_T = 16'h0101;
  localparam logic [15:0] EV_MOVE_M = 16'h0102;
  localparam logic [15:0] EV_MOVE_C = 16'h0103;
  localparam logic [15:0] EV_COND_M = 16'h0202;
  localparam logic [15:0] EV_COND_C = 16'h0203;
  localparam logic [15:0] EV_TOGGLE = 16'h0501;
  localparam logic [15:0] EV_UNLOCK = 16'h0503;
  localparam logic [15:0] EV_START  = 16'h0601;
  localparam logic [15:0] EV_STOP   = 16'h0602;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [15:0] in_event_number;
  logic [7:0]  in_current_angle;
  logic        in_increasing;
  logic        out_valid;
  logic        out_stall;
  logic        out_event_valid;
  logic [15:0] out_event_out;
  logic [1:0]  out_move_kind;
  logic [7:0]  out_move_angle;
  logic        out_index_known;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  int errors;
  int outstanding;
  int items_seen;
  int results_seen;
  int swings;
  int cfg_writes;
  int quiet;

  tsec_cfg_t cfg_now;
  logic      fast;

  turnout_servo_event_controller DUT (.*);
  turnout_cmd_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d result items still due",
               $time, quiet, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random hold-off per item, one long hold to back up the block
  initial begin : result_sink
    int   hold;
    int   taken;
    int   hold_at;
    logic calm;
    out_stall = 1'b0;
    hold      = 0;
    taken     = 0;
    calm      = 1'b0;
    hold_at   = $urandom_range(150, 250);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken++;
        if ($urandom_range(0, 29) == 0) calm = !calm;
        hold = calm ? 0 : $urandom_range(0, 16);
        if (taken == hold_at) hold = LONG_HOLD;
      end
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  task automatic send_item(input tsec_kind_t kind, input logic [15:0] ev,
                           input logic [7:0] ang, input logic inc);
    int gap;
    if ($urandom_range(0, 29) == 0) fast = !fast;
    gap = fast ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_event_number  <= ev;
    in_current_angle <= ang;
    in_increasing    <= inc;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_reg(input tsec_cfg_idx_t idx, input logic [47:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic load_config(input tsec_cfg_t c);
    cfg_now = c;
    put_reg(CFG_ANGLES, 48'(c.angles));
    put_reg(CFG_MOVE_EV, c.move_ev);
    put_reg(CFG_COND_EV, c.cond_ev);
    put_reg(CFG_LEAVE_EV, c.leave_ev);
    put_reg(CFG_REACH_EV, c.reach_ev);
    put_reg(CFG_SERVO_EV, c.servo_ev);
    put_reg(CFG_TEST_EV, 48'(c.test_ev));
    cfg_valid <= 1'b0;
  endtask

  // drain: every expected result in, then room for items that give none
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic tsec_cfg_t random_config(input int style);
    tsec_cfg_t   c;
    logic [15:0] nums[3];
    logic [7:0]  angs[2];
    case (style)
      0: begin
        c.angles   = 24'($urandom);
        c.move_ev  = 48'({$urandom, $urandom});
        c.cond_ev  = 48'({$urandom, $urandom});
        c.leave_ev = 48'({$urandom, $urandom});
        c.reach_ev = 48'({$urandom, $urandom});
        c.servo_ev = 48'({$urandom, $urandom});
        c.test_ev  = $urandom;
      end
      1: begin
        // few distinct values, so positions and event numbers collide
        foreach (nums[i]) nums[i] = 16'($urandom_range(0, 65535));
        foreach (angs[i]) angs[i] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 3; p++) begin
          c.angles[8*p +: 8]     = angs[$urandom_range(0, 1)];
          c.move_ev[16*p +: 16]  = nums[$urandom_range(0, 2)];
          c.cond_ev[16*p +: 16]  = nums[$urandom_range(0, 2)];
          c.leave_ev[16*p +: 16] = nums[$urandom_range(0, 2)];
          c.reach_ev[16*p +: 16] = nums[$urandom_range(0, 2)];
          c.servo_ev[16*p +: 16] = nums[$urandom_range(0, 2)];
        end
        c.test_ev = {nums[$urandom_range(0, 2)], nums[$urandom_range(0, 2)]};
      end
      default: c = '1;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_event();
    logic [47:0] src;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 12) return cfg_now.test_ev[16*TEV_START +: 16];
    if (r < 20) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0:       src = cfg_now.move_ev;
      1:       src = cfg_now.cond_ev;
      2:       src = cfg_now.leave_ev;
      3:       src = cfg_now.reach_ev;
      4:       src = cfg_now.servo_ev;
      default: src = {16'd0, cfg_now.test_ev};
    endcase
    return src[16*$urandom_range(0, 2) +: 16];
  endfunction

  function automatic logic [7:0] pick_angle();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return cfg_now.angles[8*$urandom_range(0, 2) +: 8];
  endfunction

  task automatic random_item();
    int         r;
    tsec_kind_t k;
    r = $urandom_range(0, 99);
    if (r < 45) k = KIND_EVENT;
    else if (r < 65) k = KIND_TICK;
    else if (r < 80) k = KIND_REACHED;
    else k = KIND_REPORT;
    send_item(k, pick_event(), pick_angle(), 1'($urandom_range(0, 1)));
  endtask

  // n ticks at one angle, with the odd reached or report item mixed in
  task automatic tick_burst(input int n, input logic [7:0] a);
    int done;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 39) == 0) begin
        send_item($urandom_range(0, 1) ? KIND_REACHED : KIND_REPORT,
                  16'($urandom_range(0, 65535)), pick_angle(), 1'($urandom_range(0, 1)));
      end else begin
        send_item(KIND_TICK, 16'($urandom_range(0, 65535)), a, 1'($urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  // start a test cycle, let a few ticks run through it, then stop it
  task automatic run_test_cycle();
    send_item(KIND_EVENT, cfg_now.test_ev[16*TEV_START +: 16], pick_angle(), 1'b0);
    tick_burst(4, cfg_now.angles[8*THROWN_POS +: 8]);
    send_item(KIND_EVENT, cfg_now.test_ev[16*TEV_STOP +: 16], pick_angle(), 1'b0);
  endtask

  initial begin : stimulus
    int styles[5];
    styles           = '{0, 1, 0, 2, 1};
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = KIND_EVENT;
    in_event_number  = '0;
    in_current_angle = '0;
    in_increasing    = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_ANGLES;
    cfg_data         = '0;
    cfg_writes       = 0;
    fast             = 1'b0;
    cfg_now          = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // everything zero after reset: every event slot and position matches at once
    send_item(KIND_EVENT, 16'd0, 8'd0, 1'b0);
    send_item(KIND_REPORT, 16'd0, 8'd0, 1'b0);

    settle();
    load_config('{angles: {ANG_C, ANG_M, ANG_T},
                  move_ev: {EV_MOVE_C, EV_MOVE_M, EV_MOVE_T},
                  cond_ev: {EV_COND_C, EV_COND_M, 16'h0201},
                  leave_ev: 48'h0303_0302_0301,
                  reach_ev: 48'h0403_0402_0401,
                  servo_ev: {EV_UNLOCK, 16'h0502, EV_TOGGLE},
                  test_ev: {EV_STOP, EV_START}});
    send_item(KIND_EVENT, 16'h1234, ANG_T, 1'b0);     // unknown number
    send_item(KIND_EVENT, EV_UNLOCK, ANG_T, 1'b0);    // known, no effect
    send_item(KIND_EVENT, EV_TOGGLE, ANG_T, 1'b0);
    send_item(KIND_EVENT, EV_TOGGLE, ANG_M, 1'b0);
    send_item(KIND_EVENT, EV_TOGGLE, ANG_C, 1'b0);
    send_item(KIND_EVENT, EV_TOGGLE, 8'd255, 1'b1);
    send_item(KIND_EVENT, EV_MOVE_T, ANG_T, 1'b0);    // already there
    send_item(KIND_EVENT, EV_MOVE_C, 8'd0, 1'b0);     // angle matches no position
    send_item(KIND_REACHED, 16'hFFFF, ANG_T, 1'b0);
    send_item(KIND_REACHED, 16'd0, ANG_M, 1'b1);
    send_item(KIND_REACHED, 16'd0, ANG_M, 1'b0);
    send_item(KIND_REACHED, 16'd0, ANG_C, 1'b1);
    send_item(KIND_REACHED, 16'd0, 8'd255, 1'b1);
    send_item(KIND_REPORT, 16'd0, ANG_T, 1'b0);
    send_item(KIND_REPORT, 16'd0, ANG_M, 1'b0);
    send_item(KIND_REPORT, 16'd0, ANG_C, 1'b0);
    send_item(KIND_REPORT, 16'd0, 8'd255, 1'b0);
    send_item(KIND_TICK, 16'd0, ANG_T, 1'b0);         // not testing
    send_item(KIND_EVENT, EV_COND_M, ANG_T, 1'b0);    // takes the lock
    send_item(KIND_EVENT, EV_COND_C, ANG_M, 1'b0);    // refused, locked
    send_item(KIND_EVENT, EV_START, ANG_T, 1'b0);
    send_item(KIND_EVENT, EV_MOVE_M, ANG_T, 1'b0);    // ignored while testing
    send_item(KIND_TICK, 16'd0, 8'd255, 1'b0);
    send_item(KIND_EVENT, EV_START, ANG_T, 1'b0);     // restart mid-cycle
    send_item(KIND_TICK, 16'd0, ANG_T, 1'b0);
    send_item(KIND_EVENT, EV_STOP, 8'd0, 1'b0);

    // all angles equal, nearly all numbers equal: result list overflows
    settle();
    load_config('{angles: 24'd0, move_ev: '1, cond_ev: '1, leave_ev: '1, reach_ev: '1,
                  servo_ev: 48'hFFFF_FFFF_FFFE, test_ev: '1});
    send_item(KIND_EVENT, 16'hFFFF, 8'd0, 1'b0);
    send_item(KIND_EVENT, 16'hFFFE, 8'd0, 1'b0);

    foreach (styles[ph]) begin
      settle();
      load_config(random_config(styles[ph]));
      for (int i = 0; i < 60; i++) begin
        if (i == 20) run_test_cycle();
        random_item();
      end
    end

    settle();
    $display("Run covered %0d input items and %0d result items over %0d register writes,",
             items_seen, results_seen, cfg_writes);
    $display("with %0d full test swings and one long result hold-off.", swings);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
